@@ rtl/joystick_pan_tilt_zoom_controller_defines.svh @@
// Assertion macros for the pan/tilt/zoom joystick controller.
`ifndef JOYSTICK_PAN_TILT_ZOOM_CONTROLLER_DEFINES_SVH
`define JOYSTICK_PAN_TILT_ZOOM_CONTROLLER_DEFINES_SVH

// Condition that must hold at every edge out of reset.
`define JPTZ_ASSERT_HOLDS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("jptz: invariant violated");

// Trigger at one edge implies the condition at the next edge.
`define JPTZ_ASSERT_NEXT(label, trig, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) \
      else $error("jptz: sequencing violated");

`endif

@@ rtl/jptz_pkg.sv @@
// Shared types, constants and tables of the pan/tilt/zoom joystick controller.
package jptz_pkg;

   // Preset slots: four preset buttons, of which PRESET_COUNT are live
   localparam int PRESET_COUNT   = 4;
   localparam int PRESET_BUTTONS = 4;
   localparam int PRESET_SLOTS   = (PRESET_COUNT < PRESET_BUTTONS) ? PRESET_COUNT
                                                                   : PRESET_BUTTONS;

   // Button bit positions
   localparam int BTN_CAM1    = 0;
   localparam int BTN_CAM2    = 1;
   localparam int BTN_PRESET0 = 2;
   localparam int BTN_HOME    = 6;

   // Event bits of one poll, in execution order
   localparam int EV_JOY_MOVE = 0;
   localparam int EV_JOY_ZOOM = 1;
   localparam int EV_CAM1     = 2;
   localparam int EV_CAM2     = 3;
   localparam int EV_PRESET0  = 4;
   localparam int EV_CENTER   = EV_PRESET0 + 2 * PRESET_BUTTONS;
   localparam int EV_COUNT    = EV_CENTER + 1;

   // Register indexes of the CSR port
   localparam logic [1:0] CSR_STICK_CENTER  = 2'd0;
   localparam logic [1:0] CSR_DEAD_ZONE     = 2'd1;
   localparam logic [1:0] CSR_MOVE_INTERVAL = 2'd2;

   // Position limits and steps
   localparam logic [7:0] PAN_MAX   = 8'd180;
   localparam logic [7:0] PAN_STEP  = 8'd2;
   localparam logic [7:0] PAN_HOME  = 8'd90;
   localparam logic [6:0] TILT_MAX  = 7'd90;
   localparam logic [6:0] TILT_STEP = 7'd2;
   localparam logic [6:0] TILT_HOME = 7'd45;
   localparam logic [3:0] ZOOM_HOME = 4'd1;
   localparam logic [3:0] ZOOM_MAX  = 4'd8;

   // Queue sizes (powers of two)
   localparam int PLAN_DEPTH = 2;
   localparam int PLAN_PTR_W = $clog2(PLAN_DEPTH);
   localparam int PLAN_CNT_W = $clog2(PLAN_DEPTH + 1);
   localparam int RSP_DEPTH  = 4;
   localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_MOVE = 2'd0,
      CMD_ZOOM = 2'd1,
      CMD_CAM  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [11:0] stick_x;
      logic [11:0] stick_y;
      logic [11:0] zoom_knob;
      logic [6:0]  buttons;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      cmd_type     command;
      logic [7:0]  pan;
      logic [6:0]  tilt;
      logic [3:0]  zoom;
      logic        camera;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [11:0] stick_center;
      logic [10:0] dead_zone;
      logic [15:0] move_interval_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{stick_center: 12'd2048, dead_zone: 11'd200,
                                     move_interval_ms: 16'd50};

   // Poll after classification by the front end
   typedef struct packed {
      logic [6:0]  rise;
      logic        center_held;
      logic        move_x;
      logic        pos_x;
      logic        move_y;
      logic        pos_y;
      logic [3:0]  dial_zoom;
      logic [31:0] now_ms;
   } plan_type;

   typedef struct packed {
      logic [7:0] pan;
      logic [6:0] tilt;
      logic [3:0] zoom;
   } preset_type;

   typedef struct packed {
      logic busy;
      logic emit;
   } back_status_type;

   // Power-up preset positions
   function automatic preset_type preset_default(input int idx);
      preset_type p;
      unique case (idx)
         0:       p = '{pan: 8'd90,  tilt: 7'd45, zoom: 4'd1};
         1:       p = '{pan: 8'd45,  tilt: 7'd30, zoom: 4'd1};
         2:       p = '{pan: 8'd135, tilt: 7'd30, zoom: 4'd1};
         3:       p = '{pan: 8'd90,  tilt: 7'd60, zoom: 4'd2};
         default: p = '{pan: PAN_HOME, tilt: TILT_HOME, zoom: ZOOM_HOME};
      endcase
      return p;
   endfunction

endpackage

@@ rtl/jptz_front.sv @@
// Front end: takes polls, finds button edges, deadzone hits and the dial zoom.
module jptz_front (
   input  logic              clock,
   input  logic              reset,
   input  jptz_pkg::cfg_type cfg,
   input  jptz_pkg::req_type req_data,
   input  logic              accept,
   output jptz_pkg::plan_type plan
);
   import jptz_pkg::*;

   logic [6:0]  prev_buttons_ff, prev_buttons_in;
   logic [14:0] dial_x7;
   logic        x_hi, y_hi;
   logic [11:0] x_mag, y_mag;

   // Previous button levels, updated per accepted poll
   always_comb begin
      prev_buttons_in = accept ? req_data.buttons : prev_buttons_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_buttons_ff <= '0;
      end else begin
         prev_buttons_ff <= prev_buttons_in;
      end
   end

   // Axis offset magnitude against the rest position
   always_comb begin
      x_hi  = req_data.stick_x > cfg.stick_center;
      y_hi  = req_data.stick_y > cfg.stick_center;
      x_mag = x_hi ? req_data.stick_x - cfg.stick_center
                   : cfg.stick_center - req_data.stick_x;
      y_mag = y_hi ? req_data.stick_y - cfg.stick_center
                   : cfg.stick_center - req_data.stick_y;
   end

   // Dial times 7, top three bits, plus one
   always_comb begin
      dial_x7 = {req_data.zoom_knob, 3'b000} - {3'b000, req_data.zoom_knob};
   end

   always_comb begin
      plan.rise        = req_data.buttons & ~prev_buttons_ff;
      plan.center_held = req_data.buttons[BTN_HOME];
      plan.move_x      = x_mag > {1'b0, cfg.dead_zone};
      plan.pos_x       = x_hi;
      plan.move_y      = y_mag > {1'b0, cfg.dead_zone};
      plan.pos_y       = y_hi;
      plan.dial_zoom   = {1'b0, dial_x7[14:12]} + 4'd1;
      plan.now_ms      = req_data.now_ms;
   end

endmodule

@@ rtl/jptz_plan_queue.sv @@
// Short queue of classified polls between front and back end.
module jptz_plan_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  jptz_pkg::plan_type push_data,
   input  logic               pop,
   output jptz_pkg::plan_type head,
   output logic               valid,
   output logic               full
);
   import jptz_pkg::*;

   plan_type               mem_ff [PLAN_DEPTH];
   logic [PLAN_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PLAN_CNT_W-1:0]  cnt_ff, cnt_in;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PLAN_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PLAN_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + PLAN_CNT_W'(push) - PLAN_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign valid = cnt_ff != '0;
   assign full  = cnt_ff == PLAN_CNT_W'(PLAN_DEPTH);

endmodule

@@ rtl/jptz_back.sv @@
// Back end: holds pan/tilt/zoom state and presets, plays out one command per cycle while the result queue has room.
module jptz_back (
   input  logic                     clock,
   input  logic                     reset,
   input  jptz_pkg::cfg_type        cfg,
   input  logic                     plan_valid,
   input  jptz_pkg::plan_type       plan,
   output logic                     plan_pop,
   input  logic                     rsp_full,
   output logic                     rsp_push,
   output jptz_pkg::rsp_type        rsp_data,
   output jptz_pkg::back_status_type status
);
   import jptz_pkg::*;

   logic                 active_ff, active_in;
   logic [EV_COUNT-1:0]  mask_ff, mask_in;
   plan_type             item_ff, item_in;
   logic [7:0]           pan_ff, pan_in;
   logic [6:0]           tilt_ff, tilt_in;
   logic [3:0]           zoom_ff, zoom_in;
   logic                 cam_ff, cam_in;
   logic [31:0]          last_move_ff, last_move_in;
   preset_type           preset_ff [PRESET_SLOTS];
   preset_type           preset_in [PRESET_SLOTS];

   logic                 zoom_chg, joy_want, joy_act, finishing, emit, load;
   logic [31:0]          elapsed;
   logic [EV_COUNT-1:0]  new_mask, sel;
   logic [7:0]           pan_nx;
   logic [6:0]           tilt_nx;
   logic [3:0]           zoom_nx;
   logic                 cam_nx;
   cmd_type              cmd_nx;

   // Joystick gate and event list of the poll at the queue head
   always_comb begin
      zoom_chg = plan.dial_zoom != zoom_ff;
      joy_want = plan.move_x | plan.move_y | zoom_chg;
      elapsed  = plan.now_ms - last_move_ff;
      joy_act  = joy_want & (elapsed > {16'd0, cfg.move_interval_ms});
      new_mask = '0;
      new_mask[EV_JOY_MOVE] = joy_act & (plan.move_x | plan.move_y);
      new_mask[EV_JOY_ZOOM] = joy_act & zoom_chg;
      new_mask[EV_CAM1]     = plan.rise[BTN_CAM1];
      new_mask[EV_CAM2]     = plan.rise[BTN_CAM2];
      for (int i = 0; i < PRESET_SLOTS; i++) begin
         new_mask[EV_PRESET0 + 2 * i]     = plan.rise[BTN_PRESET0 + i];
         new_mask[EV_PRESET0 + 2 * i + 1] = plan.rise[BTN_PRESET0 + i];
      end
      new_mask[EV_CENTER]   = plan.rise[BTN_HOME];
   end

   // Handshake: emit pending events, then a closing cycle that also loads the next poll
   always_comb begin
      sel       = mask_ff & (~mask_ff + EV_COUNT'(1));
      finishing = active_ff & (mask_ff == '0);
      emit      = active_ff & (mask_ff != '0) & ~rsp_full;
      load      = plan_valid & (~active_ff | finishing);
   end

   // State after the lowest pending event
   always_comb begin
      pan_nx  = pan_ff;
      tilt_nx = tilt_ff;
      zoom_nx = zoom_ff;
      cam_nx  = cam_ff;
      cmd_nx  = CMD_MOVE;
      if (sel[EV_JOY_MOVE]) begin
         if (item_ff.move_x) begin
            if (item_ff.pos_x) begin
               pan_nx = (pan_ff > PAN_MAX - PAN_STEP) ? PAN_MAX : pan_ff + PAN_STEP;
            end else begin
               pan_nx = (pan_ff < PAN_STEP) ? 8'd0 : pan_ff - PAN_STEP;
            end
         end
         if (item_ff.move_y) begin
            if (item_ff.pos_y) begin
               tilt_nx = (tilt_ff > TILT_MAX - TILT_STEP) ? TILT_MAX : tilt_ff + TILT_STEP;
            end else begin
               tilt_nx = (tilt_ff < TILT_STEP) ? 7'd0 : tilt_ff - TILT_STEP;
            end
         end
      end
      if (sel[EV_JOY_ZOOM]) begin
         zoom_nx = item_ff.dial_zoom;
         cmd_nx  = CMD_ZOOM;
      end
      if (sel[EV_CAM1]) begin
         cam_nx = 1'b0;
         cmd_nx = CMD_CAM;
      end
      if (sel[EV_CAM2]) begin
         cam_nx = 1'b1;
         cmd_nx = CMD_CAM;
      end
      for (int i = 0; i < PRESET_SLOTS; i++) begin
         if (sel[EV_PRESET0 + 2 * i]) begin
            pan_nx  = preset_ff[i].pan;
            tilt_nx = preset_ff[i].tilt;
            zoom_nx = preset_ff[i].zoom;
         end
         if (sel[EV_PRESET0 + 2 * i + 1]) begin
            cmd_nx = CMD_ZOOM;
         end
      end
      if (sel[EV_CENTER]) begin
         pan_nx  = PAN_HOME;
         tilt_nx = TILT_HOME;
      end
   end

   // Result of this cycle's event
   always_comb begin
      rsp_push         = emit;
      rsp_data.command = cmd_nx;
      rsp_data.pan     = pan_nx;
      rsp_data.tilt    = tilt_nx;
      rsp_data.zoom    = zoom_nx;
      rsp_data.camera  = cam_nx;
      rsp_data.last    = (mask_ff & ~sel) == '0;
      plan_pop         = load;
      status.busy      = active_ff;
      status.emit      = emit;
   end

   // Next register values
   always_comb begin
      active_in    = load ? 1'b1 : (finishing ? 1'b0 : active_ff);
      mask_in      = load ? new_mask : (emit ? (mask_ff & ~sel) : mask_ff);
      item_in      = load ? plan : item_ff;
      last_move_in = (load & joy_act) ? plan.now_ms : last_move_ff;
      pan_in       = emit ? pan_nx  : pan_ff;
      tilt_in      = emit ? tilt_nx : tilt_ff;
      zoom_in      = emit ? zoom_nx : zoom_ff;
      cam_in       = emit ? cam_nx  : cam_ff;
      // preset save while center is held, after all commands of the poll
      for (int i = 0; i < PRESET_SLOTS; i++) begin
         if (finishing & item_ff.center_held & item_ff.rise[BTN_PRESET0 + i]) begin
            preset_in[i] = '{pan: pan_ff, tilt: tilt_ff, zoom: zoom_ff};
         end else begin
            preset_in[i] = preset_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         mask_ff      <= '0;
         pan_ff       <= PAN_HOME;
         tilt_ff      <= TILT_HOME;
         zoom_ff      <= ZOOM_HOME;
         cam_ff       <= 1'b0;
         last_move_ff <= '0;
         for (int i = 0; i < PRESET_SLOTS; i++) begin
            preset_ff[i] <= preset_default(i);
         end
      end else begin
         active_ff    <= active_in;
         mask_ff      <= mask_in;
         pan_ff       <= pan_in;
         tilt_ff      <= tilt_in;
         zoom_ff      <= zoom_in;
         cam_ff       <= cam_in;
         last_move_ff <= last_move_in;
         for (int i = 0; i < PRESET_SLOTS; i++) begin
            preset_ff[i] <= preset_in[i];
         end
      end
   end

   // Poll being played out
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

@@ rtl/jptz_rsp_queue.sv @@
// Result queue feeding the rsp_ port.
module jptz_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jptz_pkg::rsp_type push_data,
   input  logic              pop,
   output jptz_pkg::rsp_type head,
   output logic              empty,
   output logic              full
);
   import jptz_pkg::*;

   rsp_type               mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  do_pop;

   // Pointer and fill bookkeeping
   always_comb begin
      do_pop    = pop & (cnt_ff != '0);
      wr_ptr_in = push   ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + RSP_CNT_W'(push) - RSP_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = cnt_ff == '0;
   assign full  = cnt_ff == RSP_CNT_W'(RSP_DEPTH);

endmodule

@@ rtl/joystick_pan_tilt_zoom_controller.sv @@
// Top level of the pan/tilt/zoom joystick controller.
`include "joystick_pan_tilt_zoom_controller_defines.svh"

// Polls go in through a queue-style push port and come back as zero to thirteen
// camera commands (move, set zoom, select camera), each carrying pan, tilt, zoom
// and camera after that command, with last set on the final one of a poll. The
// front end classifies a poll in the cycle it is accepted; a two-entry queue then
// feeds the back end, which emits the commands of a poll one at a time and then
// closes the poll in a closing step that also loads the next poll. The back end
// waits whenever the four-entry result queue is full. The user must write
// registers through csr_ only while no poll is in flight; the block does not
// enforce this.
module joystick_pan_tilt_zoom_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  jptz_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output jptz_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import jptz_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             req_accept;
   plan_type         front_plan, head_plan;
   logic             plan_valid, plan_full, plan_pop;
   logic             rsp_push, rsp_full;
   rsp_type          back_rsp;
   back_status_type  back_status;
   logic             rsp_in_range;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_STICK_CENTER:  cfg_in.stick_center     = csr_wdata[11:0];
            CSR_DEAD_ZONE:     cfg_in.dead_zone        = csr_wdata[10:0];
            CSR_MOVE_INTERVAL: cfg_in.move_interval_ms = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full   = plan_full;
   assign req_accept = req_push & ~plan_full;

   jptz_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .accept   (req_accept),
      .plan     (front_plan)
   );

   jptz_plan_queue u_plan_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_plan),
      .pop       (plan_pop),
      .head      (head_plan),
      .valid     (plan_valid),
      .full      (plan_full)
   );

   jptz_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .plan_valid (plan_valid),
      .plan       (head_plan),
      .plan_pop   (plan_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_data   (back_rsp),
      .status     (back_status)
   );

   jptz_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .pop       (rsp_pop),
      .head      (rsp_data),
      .empty     (rsp_empty),
      .full      (rsp_full)
   );

   // Reported positions stay inside the mechanical limits
   assign rsp_in_range = rsp_data.pan <= PAN_MAX && rsp_data.tilt <= TILT_MAX &&
                         rsp_data.zoom >= ZOOM_HOME && rsp_data.zoom <= ZOOM_MAX;
   `JPTZ_ASSERT_HOLDS(a_rsp_range, rsp_empty || rsp_in_range)
   // An idle back end picks up a waiting poll in the next cycle
   `JPTZ_ASSERT_NEXT(a_back_pickup, plan_valid && !back_status.busy, back_status.busy)
   // The back end never writes into a full result queue
   `JPTZ_ASSERT_HOLDS(a_no_overflow, !(back_status.emit && rsp_full))

endmodule
